[sv/echo_latency_statistics_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the echo latency statistics unit
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ECHO_LATENCY_STATISTICS_UNIT_MACROS_SVH
`define ECHO_LATENCY_STATISTICS_UNIT_MACROS_SVH

// same-cycle implication
`define ELSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ELSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/elsu_pkg.sv]
// ----------------------------------------------------------------------------
// elsu_pkg
// Types, codes and fixed widths of the echo latency statistics unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package elsu_pkg;

  localparam int CMD_W      = 2;
  localparam int LEN_W      = 7;
  localparam int TYPE_W     = 8;
  localparam int EV_W       = 3;
  localparam int SEQ_W      = 16;
  localparam int ELAPSED_W  = 16;
  localparam int RTT_W      = 16;
  localparam int MS_W       = 15;
  localparam int STAT_W     = 15;
  localparam int LOSS_W     = 7;
  localparam int BAR_W      = 7;
  localparam int MPB_W      = 8;
  localparam int CAP_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REPLY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_SENT    = 3'd1;
  localparam logic [EV_W-1:0] EV_REPLY   = 3'd2;
  localparam logic [EV_W-1:0] EV_TIMEOUT = 3'd3;
  localparam logic [EV_W-1:0] EV_CLEAR   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MPB      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAP      = 2'd3;

  localparam logic [MS_W-1:0]      INTERVAL_RST    = 15'd1000;
  localparam logic [MS_W-1:0]      TIMEOUT_RST     = 15'd1000;
  localparam logic [MPB_W-1:0]     MPB_RST         = 8'd5;
  localparam logic [CAP_W-1:0]     CAP_RST         = 6'd40;
  localparam logic [STAT_W-1:0]    NO_MIN          = 15'd9999;
  localparam logic [STAT_W-1:0]    AVG_MAX         = 15'h7FFF;
  localparam logic [LEN_W-1:0]     MIN_LENGTH      = 7'd20;
  localparam logic [LOSS_W-1:0]    PERCENT         = 7'd100;
  localparam logic [TYPE_W-1:0]    ECHO_REPLY_TYPE = 8'd0;
  localparam logic [ELAPSED_W-1:0] ELAPSED_SAT     = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_ROUTE, ST_BAR_GO, ST_BAR_WAIT, ST_AVG_GO, ST_AVG_WAIT,
    ST_LOSS_GO, ST_LOSS_WAIT, ST_FINISH
  } state_t;

  typedef enum logic [1:0] {DIV_BAR, DIV_AVG, DIV_LOSS} div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     exec;
    logic     div_start;
    div_sel_t div_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [EV_W-1:0] ev;
    logic            div_done;
  } dp_sts_t;

endpackage

[sv/elsu_in_if.sv]
// ----------------------------------------------------------------------------
// elsu_in_if
// Input request channel: tick, reply arrival or clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface elsu_in_if;
  logic                        valid;
  logic                        ready;
  logic [elsu_pkg::CMD_W-1:0]  command;
  logic [elsu_pkg::LEN_W-1:0]  reply_length;
  logic [elsu_pkg::TYPE_W-1:0] reply_type;

  modport source (output valid, command, reply_length, reply_type, input ready);
  modport sink   (input valid, command, reply_length, reply_type, output ready);
endinterface

[sv/elsu_out_if.sv]
// ----------------------------------------------------------------------------
// elsu_out_if
// Result channel: event code and statistics snapshot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface elsu_out_if #(parameter int IDX_W = 6);
  logic                                valid;
  logic                                ready;
  logic [elsu_pkg::EV_W-1:0]           event_res;
  logic [elsu_pkg::SEQ_W-1:0]          sequence_res;
  logic signed [elsu_pkg::RTT_W-1:0]   latest_rtt;
  logic [elsu_pkg::STAT_W-1:0]         min_rtt;
  logic [elsu_pkg::STAT_W-1:0]         max_rtt;
  logic [elsu_pkg::STAT_W-1:0]         avg_rtt;
  logic [elsu_pkg::LOSS_W-1:0]         loss_percent;
  logic signed [elsu_pkg::BAR_W-1:0]   bar_value;
  logic [IDX_W-1:0]                    bar_index;

  modport source (output valid, event_res, sequence_res, latest_rtt, min_rtt, max_rtt,
                  avg_rtt, loss_percent, bar_value, bar_index, input ready);
  modport sink   (input valid, event_res, sequence_res, latest_rtt, min_rtt, max_rtt,
                  avg_rtt, loss_percent, bar_value, bar_index, output ready);
endinterface

[sv/elsu_cfg_if.sv]
// ----------------------------------------------------------------------------
// elsu_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface elsu_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [elsu_pkg::CFG_IDX_W-1:0]  index;
  logic [elsu_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/echo_latency_statistics_unit.sv]
// ----------------------------------------------------------------------------
// echo_latency_statistics_unit
// Flow: a tick, clear or ignored request goes from accept through EXEC and
// ROUTE to FINISH, where the result is loaded; a timeout also makes one pass,
// and a reply three passes, through the one-bit-per-cycle divider.
// Throughput: one request at a time; the next is taken in IDLE, entered as the
// result is loaded, while that result waits.
// Reset (rst_n low, synchronous) restores registers and clears statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module echo_latency_statistics_unit #(
  parameter int HISTORY_DEPTH = 42,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  elsu_in_if.sink           in_if,
  elsu_out_if.source        out_if,
  elsu_cfg_if.sink          cfg_if
);
  import elsu_pkg::*;
  `include "echo_latency_statistics_unit_macros.svh"

  localparam int IDX_W = $clog2(HISTORY_DEPTH);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] bar_index;
  logic             bar_wr;

  assign cfg_if.ready = 1'b1;

  elsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  elsu_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .COUNT_WIDTH   (COUNT_WIDTH),
    .IDX_W         (IDX_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_if.command),
    .in_reply_length  (in_if.reply_length),
    .in_reply_type    (in_if.reply_type),
    .cfg_wr           (cfg_if.valid),
    .cfg_index        (cfg_if.index),
    .cfg_data         (cfg_if.data),
    .out_event_res    (out_if.event_res),
    .out_sequence_res (out_if.sequence_res),
    .out_latest_rtt   (out_if.latest_rtt),
    .out_min_rtt      (out_if.min_rtt),
    .out_max_rtt      (out_if.max_rtt),
    .out_avg_rtt      (out_if.avg_rtt),
    .out_loss_percent (out_if.loss_percent),
    .out_bar_value    (out_if.bar_value),
    .out_bar_index    (bar_index)
  );

  assign out_if.bar_index = bar_index;
  assign bar_wr = (out_if.event_res == EV_REPLY) || (out_if.event_res == EV_TIMEOUT);

  `ELSU_ASSERT_NXT(a_one_req, in_if.valid && in_if.ready, !in_if.ready, "second request taken")
  `ELSU_ASSERT_IMP(a_idx_rng, out_if.valid, bar_index <= IDX_W'(HISTORY_DEPTH - 1), "bad index")
  `ELSU_ASSERT_IMP(a_loss_rng, out_if.valid, out_if.loss_percent <= PERCENT, "loss above 100")
  `ELSU_ASSERT_IMP(a_bar_idle, out_if.valid && !bar_wr, out_if.bar_value == '0, "stray bar")
endmodule

[sv/elsu_div.sv]
// ----------------------------------------------------------------------------
// elsu_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elsu_div #(
  parameter int NW = 39,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNTW = $clog2(NW);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   rem_r;
  logic [NW-1:0]   quo_r;
  logic [DW-1:0]   den_r;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

[sv/elsu_ctrl.sv]
// ----------------------------------------------------------------------------
// elsu_ctrl
// Sequencer: accept, update, divisions, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elsu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output elsu_pkg::dp_cmd_t cmd,
  input  elsu_pkg::dp_sts_t sts
);
  import elsu_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:      state_nxt = ST_ROUTE;
      ST_ROUTE: begin
        if (sts.ev == EV_REPLY) state_nxt = ST_BAR_GO;
        else if (sts.ev == EV_TIMEOUT) state_nxt = ST_LOSS_GO;
        else state_nxt = ST_FINISH;
      end
      ST_BAR_GO:    state_nxt = ST_BAR_WAIT;
      ST_BAR_WAIT:  if (sts.div_done) state_nxt = ST_AVG_GO;
      ST_AVG_GO:    state_nxt = ST_AVG_WAIT;
      ST_AVG_WAIT:  if (sts.div_done) state_nxt = ST_LOSS_GO;
      ST_LOSS_GO:   state_nxt = ST_LOSS_WAIT;
      ST_LOSS_WAIT: if (sts.div_done) state_nxt = ST_FINISH;
      ST_FINISH:    if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = DIV_BAR;
    cmd.out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC:      cmd.exec = 1'b1;
      ST_BAR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_BAR;
      end
      ST_BAR_WAIT:  cmd.div_sel = DIV_BAR;
      ST_AVG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AVG;
      end
      ST_AVG_WAIT:  cmd.div_sel = DIV_AVG;
      ST_LOSS_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_LOSS;
      end
      ST_LOSS_WAIT: cmd.div_sel = DIV_LOSS;
      ST_FINISH:    cmd.out_load = out_free;
      default:      in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
endmodule

[sv/elsu_dp.sv]
// ----------------------------------------------------------------------------
// elsu_dp
// Statistics registers, request timing, shared divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elsu_dp #(
  parameter int HISTORY_DEPTH = 42,
  parameter int COUNT_WIDTH   = 32,
  parameter int IDX_W         = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  elsu_pkg::dp_cmd_t                  cmd,
  output elsu_pkg::dp_sts_t                  sts,
  input  logic [elsu_pkg::CMD_W-1:0]         in_command,
  input  logic [elsu_pkg::LEN_W-1:0]         in_reply_length,
  input  logic [elsu_pkg::TYPE_W-1:0]        in_reply_type,
  input  logic                               cfg_wr,
  input  logic [elsu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [elsu_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [elsu_pkg::EV_W-1:0]          out_event_res,
  output logic [elsu_pkg::SEQ_W-1:0]         out_sequence_res,
  output logic signed [elsu_pkg::RTT_W-1:0]  out_latest_rtt,
  output logic [elsu_pkg::STAT_W-1:0]        out_min_rtt,
  output logic [elsu_pkg::STAT_W-1:0]        out_max_rtt,
  output logic [elsu_pkg::STAT_W-1:0]        out_avg_rtt,
  output logic [elsu_pkg::LOSS_W-1:0]        out_loss_percent,
  output logic signed [elsu_pkg::BAR_W-1:0]  out_bar_value,
  output logic [IDX_W-1:0]                   out_bar_index
);
  import elsu_pkg::*;

  localparam int CW   = COUNT_WIDTH;
  localparam int NW   = COUNT_WIDTH + LOSS_W;
  localparam int SUMW = ((CW > STAT_W) ? CW : STAT_W) + 1;

  logic [CMD_W-1:0]        cmd_r;
  logic [LEN_W-1:0]        len_r;
  logic [TYPE_W-1:0]       typ_r;
  logic [MS_W-1:0]         interval_r;
  logic [MS_W-1:0]         timeout_r;
  logic [MPB_W-1:0]        mpb_r;
  logic [CAP_W-1:0]        cap_r;
  logic [ELAPSED_W-1:0]    elapsed_r;
  logic                    outst_r;
  logic [SEQ_W-1:0]        nseq_r;
  logic signed [RTT_W-1:0] last_r;
  logic [STAT_W-1:0]       min_r;
  logic [STAT_W-1:0]       max_r;
  logic [STAT_W-1:0]       avg_r;
  logic [CW-1:0]           sum_r;
  logic [CW-1:0]           att_r;
  logic [CW-1:0]           suc_r;
  logic [LOSS_W-1:0]       loss_r;
  logic [IDX_W-1:0]        pos_r;
  logic [EV_W-1:0]         ev_r;
  logic [SEQ_W-1:0]        seq_r;
  logic signed [BAR_W-1:0] bval_r;
  logic [IDX_W-1:0]        bidx_r;

  logic [ELAPSED_W-1:0] el_inc;
  logic                 timeout_hit;
  logic                 send_hit;
  logic                 reply_ok;
  logic [STAT_W-1:0]    rtt;
  logic [IDX_W-1:0]     pos_inc;
  logic [CW-1:0]        att_inc;
  logic [CW-1:0]        suc_inc;
  logic [SUMW-1:0]      sum_ext;
  logic [CW-1:0]        sum_sat;
  logic [CW-1:0]        lost;
  logic                 loss_zero;
  logic [NW-1:0]        div_num;
  logic [CW-1:0]        div_den;
  logic                 div_done;
  logic [NW-1:0]        div_quo;
  logic [CAP_W-1:0]     bar_clip;

  assign el_inc      = (elapsed_r == ELAPSED_SAT) ? elapsed_r : elapsed_r + 1'b1;
  assign timeout_hit = outst_r && (el_inc > {1'b0, timeout_r});
  assign send_hit    = !outst_r && (el_inc >= {1'b0, interval_r});
  assign reply_ok    = outst_r && (len_r >= MIN_LENGTH) && (typ_r == ECHO_REPLY_TYPE)
                       && (elapsed_r <= {1'b0, timeout_r});
  assign rtt         = elapsed_r[STAT_W-1:0];
  assign pos_inc     = (pos_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : pos_r + 1'b1;
  assign att_inc     = (&att_r) ? att_r : att_r + 1'b1;
  assign suc_inc     = (&suc_r) ? suc_r : suc_r + 1'b1;
  assign sum_ext     = SUMW'(sum_r) + SUMW'(rtt);
  assign sum_sat     = (sum_ext > SUMW'({CW{1'b1}})) ? {CW{1'b1}} : sum_ext[CW-1:0];
  assign lost        = att_r - suc_r;
  assign loss_zero   = (att_r == '0) || (suc_r >= att_r);

  always_comb begin
    case (cmd.div_sel)
      DIV_BAR: begin
        div_num = NW'(rtt);
        div_den = (mpb_r == '0) ? CW'(1) : CW'(mpb_r);
      end
      DIV_AVG: begin
        div_num = NW'(sum_r);
        div_den = suc_r;
      end
      DIV_LOSS: begin
        div_num = NW'(lost) * NW'(PERCENT);
        div_den = att_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  always_comb begin
    if (div_quo > NW'(cap_r)) bar_clip = cap_r;
    else bar_clip = div_quo[CAP_W-1:0];
    if (bar_clip == '0) bar_clip = CAP_W'(1);
  end

  elsu_div #(.NW(NW), .DW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      len_r <= in_reply_length;
      typ_r <= in_reply_type;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
      timeout_r  <= TIMEOUT_RST;
      mpb_r      <= MPB_RST;
      cap_r      <= CAP_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_INTERVAL: interval_r <= cfg_data;
        REG_TIMEOUT:  timeout_r  <= cfg_data;
        REG_MPB:      mpb_r      <= cfg_data[MPB_W-1:0];
        REG_CAP:      cap_r      <= cfg_data[CAP_W-1:0];
        default:      cap_r      <= cap_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= ELAPSED_SAT;
      outst_r   <= 1'b0;
      nseq_r    <= '0;
      last_r    <= '1;
      min_r     <= NO_MIN;
      max_r     <= '0;
      avg_r     <= '0;
      sum_r     <= '0;
      att_r     <= '0;
      suc_r     <= '0;
      loss_r    <= '0;
      pos_r     <= '0;
      ev_r      <= EV_NONE;
    end else if (cmd.exec) begin
      ev_r   <= EV_NONE;
      seq_r  <= '0;
      bval_r <= '0;
      bidx_r <= '0;
      case (cmd_r)
        CMD_TICK: begin
          elapsed_r <= el_inc;
          if (timeout_hit) begin
            outst_r <= 1'b0;
            att_r   <= att_inc;
            last_r  <= '1;
            bval_r  <= '1;
            bidx_r  <= pos_r;
            pos_r   <= pos_inc;
            ev_r    <= EV_TIMEOUT;
          end else if (send_hit) begin
            seq_r     <= nseq_r;
            nseq_r    <= nseq_r + 1'b1;
            outst_r   <= 1'b1;
            elapsed_r <= '0;
            ev_r      <= EV_SENT;
          end
        end
        CMD_REPLY: begin
          if (reply_ok) begin
            last_r  <= RTT_W'(rtt);
            if ((suc_r == '0) || (rtt < min_r)) min_r <= rtt;
            if (rtt > max_r) max_r <= rtt;
            sum_r   <= sum_sat;
            suc_r   <= suc_inc;
            att_r   <= att_inc;
            bidx_r  <= pos_r;
            pos_r   <= pos_inc;
            outst_r <= 1'b0;
            ev_r    <= EV_REPLY;
          end
        end
        CMD_CLEAR: begin
          min_r  <= NO_MIN;
          max_r  <= '0;
          avg_r  <= '0;
          sum_r  <= '0;
          att_r  <= '0;
          suc_r  <= '0;
          loss_r <= '0;
          pos_r  <= '0;
          ev_r   <= EV_CLEAR;
        end
        default: ev_r <= EV_NONE;
      endcase
    end else if (div_done) begin
      case (cmd.div_sel)
        DIV_BAR:  bval_r <= BAR_W'(bar_clip);
        DIV_AVG:  avg_r  <= (div_quo > NW'(AVG_MAX)) ? AVG_MAX : div_quo[STAT_W-1:0];
        DIV_LOSS: loss_r <= loss_zero ? '0 : div_quo[LOSS_W-1:0];
        default:  avg_r  <= avg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_event_res    <= ev_r;
      out_sequence_res <= seq_r;
      out_latest_rtt   <= last_r;
      out_min_rtt      <= (suc_r == '0) ? '0 : min_r;
      out_max_rtt      <= max_r;
      out_avg_rtt      <= avg_r;
      out_loss_percent <= loss_r;
      out_bar_value    <= bval_r;
      out_bar_index    <= bidx_r;
    end
  end

  assign sts.ev       = ev_r;
  assign sts.div_done = div_done;
endmodule

[verif/echo_latency_statistics_unit_tb.sv]
// ----------------------------------------------------------------------------
// echo_latency_statistics_unit_tb
// Self-checking bench: drives ticks, replies and clears with random stalls on
// both channels, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module echo_latency_statistics_unit_tb;
  import elsu_pkg::*;

  localparam int  RING_DEPTH  = 42;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  DRAIN_WAIT  = 150;
  localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

  typedef struct {
    logic [EV_W-1:0]   ev;
    logic [SEQ_W-1:0]  seq;
    logic [RTT_W-1:0]  latest;
    logic [STAT_W-1:0] mn;
    logic [STAT_W-1:0] mx;
    logic [STAT_W-1:0] avg;
    logic [LOSS_W-1:0] loss;
    logic [BAR_W-1:0]  bar;
    logic [5:0]        idx;
  } probe_result_t;

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   error_count;
  int   cycle_count;

  elsu_in_if      in_if ();
  elsu_out_if #(6) out_if ();
  elsu_cfg_if     cfg_if ();

  echo_latency_statistics_unit #(.HISTORY_DEPTH(RING_DEPTH), .COUNT_WIDTH(32)) DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  // predicted state
  logic [MS_W-1:0]      interval_q, timeout_q;
  logic [MPB_W-1:0]     mpb_q;
  logic [CAP_W-1:0]     cap_q;
  logic [15:0]          elapsed;
  bit                   pending;
  logic [15:0]          next_seq;
  logic signed [15:0]   last_rtt;
  logic [15:0]          smallest, largest;
  logic [31:0]          rtt_total, attempts, successes;
  logic [6:0]           loss_pct;
  logic [5:0]           ring_pos;

  probe_result_t expected_q[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void refresh_loss();
    longint unsigned lost;
    if (attempts == 0 || successes >= attempts) loss_pct = '0;
    else begin
      lost = longint'(attempts - successes);
      loss_pct = 7'(lost * 100 / longint'(attempts));
    end
  endfunction

  function automatic void clear_stats();
    smallest  = 16'(NO_MIN);
    largest   = '0;
    rtt_total = '0;
    attempts  = '0;
    successes = '0;
    loss_pct  = '0;
    ring_pos  = '0;
  endfunction

  function automatic logic [5:0] ring_write();
    logic [5:0] p;
    p = ring_pos;
    ring_pos = (p == RING_DEPTH - 1) ? 6'd0 : p + 6'd1;
    return p;
  endfunction

  function automatic void reset_model();
    interval_q = INTERVAL_RST;
    timeout_q  = TIMEOUT_RST;
    mpb_q      = MPB_RST;
    cap_q      = CAP_RST;
    elapsed    = ELAPSED_SAT;
    pending    = 0;
    next_seq   = '0;
    last_rtt   = -16'sd1;
    clear_stats();
  endfunction

  function automatic void predict_probe(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len,
                                        logic [TYPE_W-1:0] typ);
    probe_result_t r;
    logic [15:0] rtt, bar, dv;
    logic [31:0] avg;
    r.ev = EV_NONE; r.seq = '0; r.bar = '0; r.idx = '0;
    if (cmd == CMD_TICK) begin
      if (elapsed != ELAPSED_SAT) elapsed = elapsed + 16'd1;
      if (pending && elapsed > {1'b0, timeout_q}) begin
        pending   = 0;
        attempts  = sat_inc(attempts, 1);
        refresh_loss();
        last_rtt  = -16'sd1;
        r.bar     = '1;
        r.idx     = ring_write();
        r.ev      = EV_TIMEOUT;
      end else if (!pending && elapsed >= {1'b0, interval_q}) begin
        r.seq    = next_seq;
        next_seq = next_seq + 16'd1;
        pending  = 1;
        elapsed  = '0;
        r.ev     = EV_SENT;
      end
    end else if (cmd == CMD_REPLY) begin
      if (pending && len >= MIN_LENGTH && typ == ECHO_REPLY_TYPE &&
          elapsed <= {1'b0, timeout_q}) begin
        rtt = elapsed;
        dv  = (mpb_q == 0) ? 16'd1 : {8'd0, mpb_q};
        bar = rtt / dv;
        last_rtt = rtt;
        if (successes == 0 || rtt < smallest) smallest = rtt;
        if (rtt > largest) largest = rtt;
        rtt_total = sat_inc(rtt_total, {16'd0, rtt});
        successes = sat_inc(successes, 1);
        attempts  = sat_inc(attempts, 1);
        if (bar > {10'd0, cap_q}) bar = {10'd0, cap_q};
        if (bar < 1) bar = 16'd1;
        r.bar = bar[6:0];
        r.idx = ring_write();
        refresh_loss();
        pending = 0;
        r.ev = EV_REPLY;
      end
    end else if (cmd == CMD_CLEAR) begin
      clear_stats();
      r.ev = EV_CLEAR;
    end
    if (successes == 0) begin
      r.avg = '0; r.mn = '0;
    end else begin
      avg  = rtt_total / successes;
      r.avg = (avg > 32'd32767) ? AVG_MAX : avg[14:0];
      r.mn  = smallest[14:0];
    end
    r.latest = last_rtt;
    r.mx     = largest[14:0];
    r.loss   = loss_pct;
    expected_q.push_back(r);
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(negedge clk) out_if.ready <= no_idle || ($urandom_range(99) >= 35);

  always @(posedge clk) begin
    probe_result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request pending");
        error_count++;
      end else begin
        e = expected_q.pop_front();
        check_field("event_res", e.ev, out_if.event_res);
        check_field("sequence_res", e.seq, out_if.sequence_res);
        check_field("latest_rtt", $signed(e.latest), out_if.latest_rtt);
        check_field("min_rtt", e.mn, out_if.min_rtt);
        check_field("max_rtt", e.mx, out_if.max_rtt);
        check_field("avg_rtt", e.avg, out_if.avg_rtt);
        check_field("loss_percent", e.loss, out_if.loss_percent);
        check_field("bar_value", $signed(e.bar), out_if.bar_value);
        check_field("bar_index", e.idx, out_if.bar_index);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_probe(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len,
                            logic [TYPE_W-1:0] typ);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.reply_length <= len;
    in_if.reply_type   <= typ;
    do @(posedge clk); while (!in_if.ready);
    predict_probe(cmd, len, typ);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_INTERVAL: interval_q = data;
      REG_TIMEOUT:  timeout_q  = data;
      REG_MPB:      mpb_q      = data[MPB_W-1:0];
      REG_CAP:      cap_q      = data[CAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(int iv, int to, int mpb, int cap);
    write_reg(REG_INTERVAL, CFG_DATA_W'(iv));
    write_reg(REG_TIMEOUT, CFG_DATA_W'(to));
    write_reg(REG_MPB, CFG_DATA_W'(mpb));
    write_reg(REG_CAP, CFG_DATA_W'(cap));
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(99);
    if (r < 60)
      send_probe(CMD_TICK, LEN_W'($urandom_range(127)), TYPE_W'($urandom_range(255)));
    else if (r < 85)
      send_probe(CMD_REPLY, LEN_W'($urandom_range(127, 20)), ECHO_REPLY_TYPE);
    else if (r < 94)
      send_probe(CMD_REPLY, LEN_W'($urandom_range(127)),
                 ($urandom_range(1) ? 8'(ECHO_REPLY_TYPE) : 8'($urandom_range(255))));
    else if (r < 97)
      send_probe(CMD_CLEAR, LEN_W'($urandom_range(127)), TYPE_W'($urandom_range(255)));
    else
      send_probe(CMD_BAD, LEN_W'($urandom_range(127)), TYPE_W'($urandom_range(255)));
  endtask

  task automatic test_directed();
    send_probe(CMD_TICK, '0, '0);
    send_probe(CMD_REPLY, 7'd127, 8'd255);
    send_probe(CMD_REPLY, 7'd19, ECHO_REPLY_TYPE);
    send_probe(CMD_REPLY, MIN_LENGTH, ECHO_REPLY_TYPE);
    send_probe(CMD_REPLY, 7'd127, ECHO_REPLY_TYPE);
    send_probe(CMD_BAD, 7'd127, 8'd255);
    send_probe(CMD_CLEAR, '0, '0);
    set_config(1, 1, 0, 0);
    send_probe(CMD_TICK, '0, '0);
    send_probe(CMD_TICK, '0, '0);
    send_probe(CMD_TICK, '0, '0);
    send_probe(CMD_TICK, '0, '0);
    send_probe(CMD_TICK, '0, '0);
    send_probe(CMD_REPLY, 7'd64, ECHO_REPLY_TYPE);
    send_probe(CMD_TICK, '0, '0);
    send_probe(CMD_TICK, '0, '0);
    send_probe(CMD_REPLY, 7'd64, 8'd1);
    send_probe(CMD_TICK, '0, '0);
    send_probe(CMD_TICK, '0, '0);
    send_probe(CMD_CLEAR, 7'd127, 8'd255);
  endtask

  task automatic test_extremes();
    set_config(32767, 32766, 255, 63);
    repeat (20) send_random();
    set_config(1, 32766, 1, 63);
    for (int i = 0; i < 120; i++) begin
      if (i % 40 == 39) send_probe(CMD_REPLY, 7'd64, ECHO_REPLY_TYPE);
      else send_probe(CMD_TICK, '0, '0);
    end
    set_config(1, 1, 0, 0);
    repeat (150) send_random();
  endtask

  task automatic test_random();
    for (int p = 0; p < 5; p++) begin
      set_config($urandom_range(30, 1), $urandom_range(40, 1), $urandom_range(20),
                 $urandom_range(63));
      no_idle = (p == 2);
      repeat (300) send_random();
    end
    no_idle = 0;
  endtask

  initial begin
    error_count  = 0;
    cycle_count  = 0;
    no_idle      = 0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.command = CMD_TICK;
    in_if.reply_length = '0;
    in_if.reply_type   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_INTERVAL;
    cfg_if.data  = '0;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_extremes();
    test_random();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
